@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef enum logic [1:0] {
        OP_ABSORB = 2'd0,
        OP_ABSORB_FINISH = 2'd1,
        OP_FINISH = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // queue entry from front to back
    typedef struct packed {
        logic       finish;
        logic       has_byte;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire [15:0]       s_tdata,
    output logic             q_valid,
    input  wire              q_ready,
    output sha_pkg::cmd_t    q_cmd
);
    import sha_pkg::*;

    cmd_t                q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push;
    logic                pop;
    op_t                 op;
    cmd_t                cmd;

    assign op = op_t'(s_tdata[1:0]);
    assign s_tready = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH))
                      || (op == OP_UNUSED);

    always_comb
    begin
        cmd.data = s_tdata[9:2];
        cmd.has_byte = 1'b0;
        cmd.finish = 1'b0;
        case (op)
            OP_ABSORB:        cmd.has_byte = 1'b1;
            OP_ABSORB_FINISH:
            begin
                cmd.has_byte = 1'b1;
                cmd.finish = 1'b1;
            end
            OP_FINISH:        cmd.finish = 1'b1;
            default:          cmd.has_byte = 1'b0;
        endcase
    end

    assign push = s_tvalid && s_tready && (op != OP_UNUSED);
    assign q_valid = (count_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_cmd = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/sha_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_valid,
    output logic             q_ready,
    input  sha_pkg::cmd_t    q_cmd,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    state_t      after_add_reg;  // where to go once the hash update is done
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];     // message schedule window, w_reg[0] is oldest
    logic [5:0]  fill_reg;
    logic [63:0] msg_bytes_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic [2:0]  len_idx_reg;
    logic [2:0]  out_idx_reg;

    logic        put;
    logic [7:0]  put_byte;
    logic [31:0] t1, t2, s0, s1, w_new;

    always_comb
    begin
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + ROUND_K[round_reg] + w_reg[0];
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.has_byte && fill_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (q_cmd.finish)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK, ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
                else if (fill_reg == LEN_OFFSET - 6'd1)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_LEN:
            begin
                if (len_idx_reg == 3'd7)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = after_add_reg;
            end
            ST_OUT:
            begin
                if (m_tready && out_idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_ready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata = {5'd0, hash_reg[out_idx_reg], out_idx_reg};
        m_tlast = (out_idx_reg == 3'd7);
        put = 1'b0;
        put_byte = q_cmd.data;
        case (state_reg)
            ST_IDLE:
            begin
                put = q_valid && q_cmd.has_byte;
            end
            ST_MARK:
            begin
                put = 1'b1;
                put_byte = PAD_BYTE;
            end
            ST_PAD:
            begin
                put = 1'b1;
                put_byte = 8'h00;
            end
            ST_LEN:
            begin
                put = 1'b1;
                put_byte = bits_reg[63:56];
            end
            default: put = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_add_reg <= ST_IDLE;
            fill_reg <= '0;
            msg_bytes_reg <= '0;
            bits_reg <= '0;
            round_reg <= '0;
            len_idx_reg <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (put)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.has_byte)
                        begin
                            msg_bytes_reg <= msg_bytes_reg + 64'd1;
                        end
                        after_add_reg <= q_cmd.finish ? ST_MARK : ST_IDLE;
                    end
                end
                ST_MARK:
                begin
                    bits_reg <= {msg_bytes_reg[60:0], 3'b000};
                    len_idx_reg <= '0;
                    after_add_reg <= ST_PAD;
                end
                ST_LEN:
                begin
                    bits_reg <= {bits_reg[55:0], 8'h00};
                    len_idx_reg <= len_idx_reg + 3'd1;
                    after_add_reg <= ST_OUT;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    out_idx_reg <= '0;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= INIT_HASH[i];
                            end
                            msg_bytes_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            else
            begin
                round_reg <= '0;
            end
        end
    end

    // block buffer as a shifting word window; rounds shift the schedule
    always_ff @(posedge clk)
    begin
        if (put)
        begin
            w_reg[fill_reg[5:2]] <= {w_reg[fill_reg[5:2]][23:0], put_byte};
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/sha256_byte_stream_hasher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata fields (low bit up)                 | tlast
// s_axis  | in  | operation[1:0], data_byte[9:2]            | -
// m_axis  | out | word_index[2:0], digest_word[34:3]        | last_word
// The back end writes each byte into the block buffer; the 64th byte of a
// block also starts the 64 rounds and then the hash update. A finish writes
// the 0x80 byte, the zero bytes and the eight length bytes, runs one or two
// compressions, then streams eight words as m_axis_tready allows.
// A four-item queue takes items while the back end is busy; once it is full
// s_axis_tready drops, except for the unused operation, which is dropped.
// rst_n clears all control state and loads the initial hash values.
module sha256_byte_stream_hasher_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // operation, data_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // word_index, digest_word
    output logic        m_axis_tlast
);
    import sha_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    sha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    sha_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import sha_pkg::*;

    class digest_board;
        logic [31:0] hash [8];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] msg_len;
        logic [35:0] pending [$];   // {word_index, digest_word, last_word}
        int          errors;
        int          digests;

        function new();
            errors = 0;
            digests = 0;
            restart();
        endfunction

        function void restart();
            foreach (hash[i]) hash[i] = INIT_HASH[i];
            fill = 0;
            msg_len = 64'd0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            foreach (v[i]) v[i] = hash[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (hash[i]) hash[i] = hash[i] + v[i];
        endfunction

        function void push_byte(logic [7:0] b);
            blk[fill] = b;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_item(op_t op, logic [7:0] b);
            logic [63:0] bits;
            if (op == OP_UNUSED) return;
            if (op != OP_FINISH)
            begin
                push_byte(b);
                msg_len++;
            end
            if (op == OP_ABSORB) return;
            bits = msg_len << 3;
            push_byte(PAD_BYTE);
            while (fill != int'(LEN_OFFSET)) push_byte(8'h00);
            for (int i = 7; i >= 0; i--) push_byte(bits[8*i +: 8]);
            for (int i = 0; i < 8; i++)
                pending.insert(pending.size(), {3'(i), hash[i], i == 7});
            digests++;
            restart();
        endfunction

        function void check_word(logic [2:0] idx, logic [31:0] word, logic last);
            logic [35:0] exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word idx=%0d data=%h last=%b", idx, word, last);
                return;
            end
            exp = pending.pop_front();
            if (exp != {idx, word, last})
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp idx=%0d data=%h last=%b got idx=%0d data=%h last=%b",
                             exp[35:33], exp[32:1], exp[0], idx, word, last);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    digest_board board = new();
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    bit  hold_req = 0;

    always #4 clk = ~clk;

    sha256_byte_stream_hasher_core dut (.*);

    task automatic send_item(op_t op, logic [7:0] b);
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, b, 2'(op)};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_item(op, b);
        items_sent++;
    endtask

    task automatic send_message(int len, bit merged_finish);
        for (int i = 0; i < len; i++)
            send_item((merged_finish && i == len - 1) ? OP_ABSORB_FINISH : OP_ABSORB,
                      8'($urandom));
        if (!merged_finish || len == 0) send_item(OP_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tlast);
        if (rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("timeout");
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        bit hold_done;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1;
            end
            else if (no_gaps)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_FINISH, 8'hff);
        send_item(OP_UNUSED, 8'hff);
        send_item(OP_ABSORB_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_ABSORB, 8'h55);
        send_item(OP_ABSORB_FINISH, 8'haa);
        drain();
        send_message(55, 1);
        send_message(56, 0);
        drain();

        hold_req = 1;
        send_message(3, 1);
        send_message(20, 1);
        send_message(5, 0);
        drain();

        while (items_sent < 230)
        begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(60, 130);
                1: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            if (len > 232 - items_sent) len = 232 - items_sent;
            if ($urandom_range(0, 3) == 0) send_item(OP_UNUSED, 8'($urandom));
            send_message(len, $urandom_range(0, 1));
        end
        no_gaps = 1;
        send_message(10, 1);
        send_message(64, 0);
        drain();
        repeat (200) @(posedge clk);

        $display("%0d items sent, %0d digests, lengths 0..130 bytes incl. block edges",
                 items_sent, board.digests);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_back.sv
rtl/sha256_byte_stream_hasher_core.sv
dv/testbench.sv
